FILE: rtl/core/rzpp_pkg.sv
// rotozoom pixel pipeline package: texture geometry, wrap constants, register
// indexes and transaction kinds. no dependencies.
`default_nettype none

package rzpp_pkg;

  // texture store geometry
  localparam int TEX_W    = 320;
  localparam int TEX_H    = 240;
  localparam int TEX_SIZE = TEX_W * TEX_H;
  localparam int ADDR_W   = $clog2(TEX_SIZE);
  localparam int TU_W     = $clog2(TEX_W);
  localparam int TV_W     = $clog2(TEX_H);

  // payload widths
  localparam int STEP_W = 22;
  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int PIX_W  = 8;
  localparam int RAD_W  = 8;
  localparam int FADE_W = 9;
  localparam int CIDX_W = 3;

  // 16.16 affine arithmetic
  localparam int           ACC_W  = 32;
  localparam logic [31:0]  U_BASE = 32'(160) << 16;
  localparam logic [31:0]  V_BASE = 32'(120) << 16;
  localparam int           X_CTR  = 160;
  localparam int           Y_CTR  = 120;

  // floor-modulo of the 16-bit integer part: bias by a multiple of the size to
  // make it positive, then divide by reciprocal with one correction step
  localparam int N_W      = 17;
  localparam int RCP_SH   = 17;
  localparam int RCP_W    = 14;
  localparam int PROD_W   = N_W + RCP_W;
  localparam int QE_W     = PROD_W - RCP_SH;
  localparam logic [N_W-1:0]   OFF_U = N_W'(TEX_W * ((32768 + TEX_W - 1) / TEX_W));
  localparam logic [N_W-1:0]   OFF_V = N_W'(TEX_H * ((32768 + TEX_H - 1) / TEX_H));
  localparam logic [RCP_W-1:0] RCP_U = RCP_W'((1 << RCP_SH) / TEX_W);
  localparam logic [RCP_W-1:0] RCP_V = RCP_W'((1 << RCP_SH) / TEX_H);

  // result queue
  localparam int FIFO_D  = 16;
  localparam int FIFO_AW = $clog2(FIFO_D);

  // register indexes
  localparam logic [CIDX_W-1:0] REG_STEP_XU   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_STEP_XV   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_STEP_YU   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_STEP_YV   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_IRIS      = 3'd4;
  localparam logic [CIDX_W-1:0] REG_FADE      = 3'd5;

  // transaction kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/rotozoom_pixel_pipeline.sv
// rotozoom pixel pipeline top level: affine texture mapper with iris and fade.
// depends on rzpp_pkg.
//
// usage: the item channel (item_valid/item_ready) takes either a texel load
// (kind = load) that writes texel into the 320x240 texture store at (x, y), or
// a render (kind = render) that maps screen pixel (x, y) through the 16.16
// affine transform, reads the wrapped texel and applies the iris and fade
// masks. loads outside the texture are dropped and give no result; every
// render gives exactly one color on the result channel (result_valid/ready).
// registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and writes belong to idle periods.
// throughput is one transaction per cycle while item_ready is high; a render's
// color passes through the eight-stage pipe around the single-port texture
// memory. loads and renders reach that memory port in order, so a render sees
// every earlier load. results go into a 16-entry queue; item_ready stays high
// while fewer than 16 renders are outstanding, so a stalled receiver only
// stops intake once 16 renders sit in the pipe and the queue together.
// synchronous reset empties the pipe and the queue and restores the register
// defaults; the texture store is not cleared and must be loaded before use.
`default_nettype none

module rotozoom_pixel_pipeline import rzpp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output      logic               item_ready,
  input  wire logic               kind,
  input  wire logic [X_W-1:0]     x,
  input  wire logic [Y_W-1:0]     y,
  input  wire logic [PIX_W-1:0]   texel,
  output      logic               result_valid,
  input  wire logic               result_ready,
  output      logic [PIX_W-1:0]   color,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [STEP_W-1:0]  cfg_data
);

  // configuration registers
  logic signed [STEP_W-1:0] step_xu, step_xv, step_yu, step_yv;
  logic [RAD_W-1:0]         iris_radius;
  logic [FADE_W-1:0]        fade_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_xu        <= STEP_W'(65536);
      step_xv        <= '0;
      step_yu        <= '0;
      step_yv        <= STEP_W'(65536);
      iris_radius    <= RAD_W'(200);
      fade_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_XU: step_xu        <= cfg_data;
        REG_STEP_XV: step_xv        <= cfg_data;
        REG_STEP_YU: step_yu        <= cfg_data;
        REG_STEP_YV: step_yv        <= cfg_data;
        REG_IRIS:    iris_radius    <= cfg_data[RAD_W-1:0];
        REG_FADE:    fade_threshold <= cfg_data[FADE_W-1:0];
        default: ;
      endcase
    end
  end

  logic item_fire, result_fire;
  assign item_fire   = item_valid && item_ready;
  assign result_fire = result_valid && result_ready;

  // stage valids: ren = render, ld = load (in range from stage 2 on)
  logic ren1, ren2, ren3, ren4, ren5, ren6, ren7, ren8;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

  // stage 1 registers
  logic [X_W-1:0]     x1;
  logic [Y_W-1:0]     y1;
  logic [PIX_W-1:0]   tex1, tex2, tex3, tex4, tex5, tex6, tex7;
  logic signed [9:0]  dx1;
  logic signed [8:0]  dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      {ren1, ren2, ren3, ren4, ren5, ren6, ren7, ren8} <= '0;
      {ld1, ld2, ld3, ld4, ld5, ld6, ld7}               <= '0;
    end else begin
      ren1 <= item_fire && (kind == KIND_RENDER);
      ld1  <= item_fire && (kind == KIND_LOAD);
      ren2 <= ren1;
      ld2  <= ld1 && (32'(x1) < TEX_W) && (32'(y1) < TEX_H);
      {ren3, ren4, ren5, ren6, ren7, ren8} <= {ren2, ren3, ren4, ren5, ren6, ren7};
      {ld3, ld4, ld5, ld6, ld7}            <= {ld2, ld3, ld4, ld5, ld6};
    end
  end

  // stage 1: capture, offsets from screen centre
  always_ff @(posedge clk) begin
    x1   <= x;
    y1   <= y;
    tex1 <= texel;
    dx1  <= $signed({1'b0, x}) - 10'sd160;
    dy1  <= $signed({1'b0, y}) - 9'sd120;
  end

  // stage 2: products
  logic signed [ACC_W-1:0] pxu, pyu, pxv, pyv;
  logic [16:0]             dxsq;
  logic [14:0]             dysq;
  logic [15:0]             rsq;
  logic                    fade2;
  logic [ADDR_W-1:0]       laddr2, laddr3, laddr4, laddr5, laddr6;
  logic signed [19:0]      sq_dx;
  logic signed [17:0]      sq_dy;

  always_comb begin
    sq_dx = 20'(dx1) * 20'(dx1);
    sq_dy = 18'(dy1) * 18'(dy1);
  end

  always_ff @(posedge clk) begin
    pxu    <= ACC_W'(dx1) * ACC_W'(step_xu);
    pyu    <= ACC_W'(dy1) * ACC_W'(step_yu);
    pxv    <= ACC_W'(dx1) * ACC_W'(step_xv);
    pyv    <= ACC_W'(dy1) * ACC_W'(step_yv);
    dxsq   <= sq_dx[16:0];
    dysq   <= sq_dy[14:0];
    rsq    <= 16'(iris_radius) * 16'(iris_radius);
    fade2  <= {1'b0, x1[7:0] ^ y1} < fade_threshold;
    laddr2 <= ADDR_W'(ADDR_W'(y1) * ADDR_W'(TEX_W) + ADDR_W'(x1));
    tex2   <= tex1;
  end

  // stage 3: affine sums with 32-bit wrap, mask decision
  logic [ACC_W-1:0] cu3, cv3;
  logic             blk3, blk4, blk5, blk6, blk7, blk8;

  always_ff @(posedge clk) begin
    cu3    <= U_BASE + pyu + pxu;
    cv3    <= V_BASE + pyv + pxv;
    blk3   <= fade2 || ((18'(dxsq) + 18'(dysq)) > 18'(rsq));
    laddr3 <= laddr2;
    tex3   <= tex2;
  end

  // stage 4: biased integer part and reciprocal product
  logic [N_W-1:0]    nu_c, nv_c, nu4, nv4;
  logic [PROD_W-1:0] pu4, pv4;

  always_comb begin
    nu_c = N_W'($signed(cu3[31:16])) + OFF_U;
    nv_c = N_W'($signed(cv3[31:16])) + OFF_V;
  end

  always_ff @(posedge clk) begin
    nu4    <= nu_c;
    nv4    <= nv_c;
    pu4    <= PROD_W'(nu_c) * PROD_W'(RCP_U);
    pv4    <= PROD_W'(nv_c) * PROD_W'(RCP_V);
    blk4   <= blk3;
    laddr4 <= laddr3;
    tex4   <= tex3;
  end

  // stage 5: remainder estimate, below twice the size
  localparam logic [N_W-1:0] TEX_W_N = N_W'(TEX_W);
  localparam logic [N_W-1:0] TEX_H_N = N_W'(TEX_H);
  logic [QE_W-1:0]  qu, qv;
  logic [TU_W:0]    ru5;
  logic [TV_W:0]    rv5;

  assign qu = pu4[PROD_W-1:RCP_SH];
  assign qv = pv4[PROD_W-1:RCP_SH];

  always_ff @(posedge clk) begin
    ru5    <= (TU_W+1)'(nu4 - N_W'(qu * TEX_W_N));
    rv5    <= (TV_W+1)'(nv4 - N_W'(qv * TEX_H_N));
    blk5   <= blk4;
    laddr5 <= laddr4;
    tex5   <= tex4;
  end

  // stage 6: final correction
  logic [TU_W-1:0] tu6;
  logic [TV_W-1:0] tv6;

  always_ff @(posedge clk) begin
    tu6    <= (ru5 >= (TU_W+1)'(TEX_W)) ? TU_W'(ru5 - (TU_W+1)'(TEX_W)) : TU_W'(ru5);
    tv6    <= (rv5 >= (TV_W+1)'(TEX_H)) ? TV_W'(rv5 - (TV_W+1)'(TEX_H)) : TV_W'(rv5);
    blk6   <= blk5;
    laddr6 <= laddr5;
    tex6   <= tex5;
  end

  // stage 7: memory address, renders and loads share the one port in order
  logic [ADDR_W-1:0] addr7;

  always_ff @(posedge clk) begin
    addr7 <= ren6 ? ADDR_W'(ADDR_W'(tv6) * ADDR_W'(TEX_W) + ADDR_W'(tu6)) : laddr6;
    blk7  <= blk6;
    tex7  <= tex6;
  end

  // texture store, single port, registered read
  logic [PIX_W-1:0] tex_mem [TEX_SIZE];
  logic [PIX_W-1:0] rdata8;

  always_ff @(posedge clk) begin
    if (ld7) begin
      tex_mem[addr7] <= tex7;
    end else begin
      rdata8 <= tex_mem[addr7];
    end
  end

  always_ff @(posedge clk) begin
    blk8 <= blk7;
  end

  // result queue and outstanding-render count
  logic [PIX_W-1:0]   fifo_mem [FIFO_D];
  logic [FIFO_AW:0]   wr_ptr, rd_ptr, pending;
  logic               take;

  assign take = item_fire && (kind == KIND_RENDER);

  always_ff @(posedge clk) begin
    if (ren8) begin
      fifo_mem[wr_ptr[FIFO_AW-1:0]] <= blk8 ? '0 : rdata8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      pending <= '0;
    end else begin
      if (ren8) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (result_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({take, result_fire})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  assign item_ready   = pending != (FIFO_AW+1)'(FIFO_D);
  assign result_valid = wr_ptr != rd_ptr;
  assign color        = fifo_mem[rd_ptr[FIFO_AW-1:0]];

endmodule

`default_nettype wire

FILE: rtl/core/rzpp_checker.sv
// port-level checks for the rotozoom pixel pipeline, bound to the top level.
// depends on rzpp_pkg.
`default_nettype none

module rzpp_checker import rzpp_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire logic [PIX_W-1:0] color,
  input wire logic             cfg_ready
);

  // a waiting result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its color
  a_color_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(color))
    else $error("color changed while stalled");

  // reset leaves the queue empty and the intake open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("not empty after reset");

  // config port never back-pressures
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("cfg port stalled");

endmodule

bind rotozoom_pixel_pipeline rzpp_checker u_rzpp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .color        (color),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire

FILE: sim/tb.sv
// testbench for rotozoom_pixel_pipeline: texel loads and pixel renders with random
// pacing on both channels, colours checked against an in-bench affine mapper.
// depends on rzpp_pkg and rotozoom_pixel_pipeline.
`default_nettype none

module tb;
  import rzpp_pkg::*;

  localparam int STEP_LIM     = 1 << 20;
  localparam int X_TOP        = (1 << X_W) - 1;
  localparam int Y_TOP        = (1 << Y_W) - 1;
  localparam int PIPE_SETTLE  = 16;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 118;
  localparam logic [CIDX_W-1:0] REG_SPARE = CIDX_W'(REG_FADE + 1);

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  // affine mapper with its own texture copy; holds the colours still owed
  class render_checker_t;
    logic [PIX_W-1:0]  tex_mem [TEX_SIZE];
    bit                written [TEX_SIZE];
    logic [STEP_W-1:0] sxu, sxv, syu, syv;
    logic [RAD_W-1:0]  radius;
    logic [FADE_W-1:0] fade;
    logic [PIX_W-1:0]  pending_colors [$];
    int                fails;

    function new();
      sxu    = STEP_W'(65536);
      sxv    = '0;
      syu    = '0;
      syv    = STEP_W'(65536);
      radius = RAD_W'(200);
      fade   = '0;
      fails  = 0;
    endfunction

    function void report(string msg);
      fails++;
      if (fails <= 10) $display("%s", msg);
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [STEP_W-1:0] val);
      case (idx)
        REG_STEP_XU: sxu = val;
        REG_STEP_XV: sxv = val;
        REG_STEP_YU: syu = val;
        REG_STEP_YV: syv = val;
        REG_IRIS:    radius = val[RAD_W-1:0];
        REG_FADE:    fade = val[FADE_W-1:0];
        default: ;
      endcase
    endfunction

    // 16.16 sum wrapped to 32 bits, integer part floor-wrapped into 0..size-1
    function int wrap_coord(longint base, longint dy, logic [STEP_W-1:0] sy,
                            longint dx, logic [STEP_W-1:0] sx, int size);
      longint           sum;
      logic [ACC_W-1:0] w;
      int               m;
      sum = base + dy * longint'($signed(sy)) + dx * longint'($signed(sx));
      w = sum[ACC_W-1:0];
      m = int'($signed(w[ACC_W-1:16])) % size;
      if (m < 0) m += size;
      return m;
    endfunction

    function int tex_addr(int px, int py);
      longint dx, dy;
      int     tu, tv;
      dx = px - X_CTR;
      dy = py - Y_CTR;
      tu = wrap_coord(longint'(U_BASE), dy, syu, dx, sxu, TEX_W);
      tv = wrap_coord(longint'(V_BASE), dy, syv, dx, sxv, TEX_H);
      return tv * TEX_W + tu;
    endfunction

    function logic [PIX_W-1:0] predict_color(int px, int py);
      int               dx, dy, d2, r2;
      logic [PIX_W-1:0] c;
      dx = px - X_CTR;
      dy = py - Y_CTR;
      c = tex_mem[tex_addr(px, py)];
      d2 = dx * dx + dy * dy;
      r2 = int'(radius) * int'(radius);
      if (d2 > r2) c = '0;
      if (((px ^ py) & 8'hFF) < int'(fade)) c = '0;
      return c;
    endfunction

    function void note_item(logic k, int px, int py, int t);
      if (k == KIND_LOAD) begin
        if (px < TEX_W && py < TEX_H) begin
          tex_mem[py * TEX_W + px] = PIX_W'(t);
          written[py * TEX_W + px] = 1'b1;
        end
      end else begin
        pending_colors.push_back(predict_color(px, py));
      end
    endfunction

    function void check_color(logic [PIX_W-1:0] got);
      logic [PIX_W-1:0] want;
      if (pending_colors.size() == 0) begin
        report($sformatf("tb: colour %0d arrived with no render outstanding", got));
        return;
      end
      want = pending_colors.pop_front();
      if (got !== want)
        report($sformatf("tb: colour mismatch, expected %0d, got %0d", want, got));
    endfunction

    function void close_out();
      if (pending_colors.size() != 0)
        report($sformatf("tb: %0d colours never arrived", pending_colors.size()));
    endfunction
  endclass

  logic               clk;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  logic               kind         = KIND_LOAD;
  logic [X_W-1:0]     x            = '0;
  logic [Y_W-1:0]     y            = '0;
  logic [PIX_W-1:0]   texel        = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [PIX_W-1:0]   color;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index    = '0;
  logic [STEP_W-1:0]  cfg_data     = '0;

  render_checker_t sb = new();

  int       burst_left = 0;
  bit       steady     = 1'b0;
  int       items_sent = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_count   = 0;

  rotozoom_pixel_pipeline dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .x            (x),
    .y            (y),
    .texel        (texel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .color        (color),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // receiver: checks every colour transaction and stalls in windows of its own
  always @(posedge clk) begin
    if (result_valid && result_ready) sb.check_color(color);
    if (rx_count == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_count = $urandom_range(20, 120);
    end
    rx_count--;
    case (rx_mode)
      RX_OPEN:   result_ready <= 1'b1;
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default:   result_ready <= (rx_count < 10);
    endcase
  end

  // bursts of back-to-back transactions separated by random gaps
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    if (steady) gap = 0;
    else if ($urandom_range(0, 7) == 0) gap = $urandom_range(5, 20);
    else gap = $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      kind <= 1'($urandom_range(0, 1));
      x <= X_W'($urandom);
      y <= Y_W'($urandom);
      texel <= PIX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic k, input int px, input int py, input int t);
    item_valid <= 1'b1;
    kind <= k;
    x <= X_W'(px);
    y <= Y_W'(py);
    texel <= PIX_W'(t);
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(k, px, py, t);
    if (k == KIND_RENDER || (px < TEX_W && py < TEX_H)) items_sent++;
    pace_sender();
  endtask

  // the texel a render will fetch is loaded first if it has never been written
  task automatic render_pixel(input int px, input int py);
    int a;
    a = sb.tex_addr(px, py);
    if (!sb.written[a]) send_item(KIND_LOAD, a % TEX_W, a / TEX_W, $urandom_range(0, 255));
    send_item(KIND_RENDER, px, py, $urandom_range(0, 255));
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [STEP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    int waited;
    item_valid <= 1'b0;
    waited = 0;
    while (sb.pending_colors.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [STEP_W-1:0] pick_step();
    int v;
    case ($urandom_range(0, 6))
      0:       v = -STEP_LIM;
      1:       v = STEP_LIM;
      2:       v = int'($urandom_range(0, 2 * STEP_LIM)) - STEP_LIM;
      3, 4:    v = int'($urandom_range(0, 262144)) - 131072;
      default: v = int'($urandom_range(0, 32768)) + 49152;
    endcase
    return STEP_W'(v);
  endfunction

  task automatic shuffle_regs();
    logic [STEP_W-1:0] d;
    write_reg(REG_STEP_XU, pick_step());
    write_reg(REG_STEP_XV, pick_step());
    write_reg(REG_STEP_YU, pick_step());
    write_reg(REG_STEP_YV, pick_step());
    // unused upper data bits carry noise half of the time
    d = ($urandom_range(0, 1) == 1) ? STEP_W'($urandom) : '0;
    case ($urandom_range(0, 4))
      0:       d[RAD_W-1:0] = '0;
      1:       d[RAD_W-1:0] = RAD_W'(200);
      2:       d[RAD_W-1:0] = '1;
      default: d[RAD_W-1:0] = RAD_W'($urandom_range(60, 200));
    endcase
    write_reg(REG_IRIS, d);
    d = ($urandom_range(0, 1) == 1) ? STEP_W'($urandom) : '0;
    case ($urandom_range(0, 7))
      0:       d[FADE_W-1:0] = FADE_W'(256);
      1:       d[FADE_W-1:0] = '1;
      2:       d[FADE_W-1:0] = FADE_W'($urandom_range(0, 256));
      3, 4:    d[FADE_W-1:0] = '0;
      default: d[FADE_W-1:0] = FADE_W'($urandom_range(0, 40));
    endcase
    write_reg(REG_FADE, d);
    if ($urandom_range(0, 2) == 0)
      write_reg(CIDX_W'(REG_SPARE + $urandom_range(0, 1)), STEP_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int px, py;
    px = ($urandom_range(0, 9) == 0) ? $urandom_range(TEX_W, X_TOP) : $urandom_range(0, TEX_W - 1);
    py = ($urandom_range(0, 9) == 0) ? $urandom_range(TEX_H, Y_TOP) : $urandom_range(0, TEX_H - 1);
    if ($urandom_range(0, 9) < 7) render_pixel(px, py);
    else send_item(KIND_LOAD, px, py, $urandom_range(0, 255));
  endtask

  initial begin
    int phase_end;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset mapping reads texel (x mod 320, y mod 240)
    send_item(KIND_LOAD, 0, 0, 8'hFF);
    send_item(KIND_LOAD, TEX_W - 1, TEX_H - 1, 8'hA5);
    send_item(KIND_LOAD, X_CTR, Y_CTR, 8'h5A);
    // loads off the texture are dropped
    send_item(KIND_LOAD, TEX_W, 0, 8'h11);
    send_item(KIND_LOAD, 0, TEX_H, 8'h22);
    send_item(KIND_LOAD, X_TOP, Y_TOP, 8'h33);
    render_pixel(0, 0);                  // exactly on the iris edge
    render_pixel(TEX_W - 1, TEX_H - 1);
    render_pixel(X_CTR, Y_CTR);
    render_pixel(X_TOP, Y_TOP);          // off screen, outside the iris
    drain();

    // steepest steps, iris closed to the centre, full fade
    write_reg(REG_STEP_XU, STEP_W'(STEP_LIM));
    write_reg(REG_STEP_XV, STEP_W'(-STEP_LIM));
    write_reg(REG_STEP_YU, STEP_W'(-STEP_LIM));
    write_reg(REG_STEP_YV, STEP_W'(STEP_LIM));
    write_reg(REG_IRIS, '0);
    write_reg(REG_FADE, STEP_W'(256));
    write_reg(REG_SPARE, STEP_W'(12345));
    cfg_valid <= 1'b0;
    render_pixel(X_CTR, Y_CTR);
    render_pixel(0, 0);
    drain();

    write_reg(REG_FADE, STEP_W'(5));
    cfg_valid <= 1'b0;
    render_pixel(X_CTR, Y_CTR);          // centre survives a zero radius
    render_pixel(X_CTR + 1, Y_CTR);
    drain();

    // fade edge: xor of 5 survives a threshold of 5, 4 does not
    write_reg(REG_IRIS, STEP_W'(200));
    cfg_valid <= 1'b0;
    render_pixel(165, 160);
    render_pixel(164, 160);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      shuffle_regs();
      steady = (p % 3 == 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_item();
      drain();
    end

    sb.close_out();
    if (sb.fails == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

FILE: rotozoom_pixel_pipeline.f
rtl/core/rzpp_pkg.sv
rtl/core/rotozoom_pixel_pipeline.sv
rtl/core/rzpp_checker.sv
sim/tb.sv
